// File: src/lzmwd_pkg.sv
// ----------------------------------------------------------------------------
// lzmwd_pkg
// Shared types and constants for the mask-word LZ decoder.
// ----------------------------------------------------------------------------
package lzmwd_pkg;

   // History store depth in words.
   localparam int HISTORY_DEPTH = 2048;
   localparam int PTR_W         = $clog2(HISTORY_DEPTH);

   localparam int WORD_W  = 16;
   localparam int DIST_W  = 11;
   localparam int LENF_W  = 5;
   localparam int LEN_W   = 6;
   localparam int COUNT_W = 12;

   // The produced-word count stops here, as the distance field cannot exceed it.
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 12'd2048;
   localparam logic [WORD_W-1:0]  MASK_TOP    = 16'h8000;
   localparam logic [LEN_W-1:0]   LEN_BIAS    = 6'd2;

   // Response tuser codes: bit 0 is end of stream, bit 1 is bad reference.
   localparam logic [1:0] USER_NONE = 2'b00;
   localparam logic [1:0] USER_END  = 2'b01;
   localparam logic [1:0] USER_BAD  = 2'b10;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

endpackage

// File: src/lzmwd_ram.sv
// ----------------------------------------------------------------------------
// lzmwd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzmwd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // Read data holds while no read is issued.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lz_mask_word_decoder.sv
// ----------------------------------------------------------------------------
// lz_mask_word_decoder
// Decoder for an LZ stream of 16-bit words steered by 16-bit mask words.
// ----------------------------------------------------------------------------
// A request carries one stream word; tuser set clears the decoder before the
// word is used. The first word, and the word after every sixteen tokens, is a
// mask word and gives no response. Each token is a literal (one response) or a
// back-reference whose words are copied one at a time out of a 2048-word
// history RAM, so overlapping copies repeat data. A zero back-reference gives
// one response with the end flag and then all words are dropped until the
// next request with tuser set. A back-reference whose distance is zero or
// reaches past the words produced so far gives one response with the bad flag
// and copies nothing. The last response caused by a request carries tlast.
// Flow control: a mask word, a literal, an end or a bad reference is taken
// while the response register is free. A back-reference keeps req_tready low
// while its words are copied: every copied word passes a read state and a
// write state on the history RAM, whose read data is registered.
// Back-pressure on the response side holds the copy in its write state. The
// history RAM needs no clearing after reset, as the distance check keeps
// every read within words already written.
// ----------------------------------------------------------------------------
module lz_mask_word_decoder
   import lzmwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] word_in
   input  logic        req_tuser,   // [0] start_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] word_out
   output logic        rsp_tlast,   // last_of_run
   output logic [1:0]  rsp_tuser    // [0] end_of_stream, [1] bad_reference
);

   // Sequencer and decoder state.
   state_type                state_ff, state_in;
   ptr_type                  wp_ff, wp_in;
   count_type                count_ff, count_in;
   word_type                 mask_word_ff, mask_word_in;
   word_type                 mask_bit_ff, mask_bit_in;
   logic                     finished_ff, finished_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [LEN_W-1:0]         remain_ff, remain_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   word_type                 rsp_word_ff, rsp_word_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;
   logic                     rsp_load;

   // History RAM ports.
   logic                     wr_en;
   ptr_type                  wr_addr;
   word_type                 wr_data;
   logic                     rd_en;
   ptr_type                  rd_addr;
   word_type                 rd_data;

   // Request view after an optional stream restart.
   logic                     req_fire;
   logic                     out_free;
   ptr_type                  eff_wp;
   count_type                eff_count;
   word_type                 eff_mask_word;
   word_type                 eff_mask_bit;
   logic                     eff_finished;
   logic                     tok_is_ref;
   logic [DIST_W-1:0]        tok_dist;
   logic [LEN_W-1:0]         tok_len;
   ptr_type                  dist_ptr;

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(HISTORY_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   function automatic count_type count_sat(input count_type c);
      count_type r;
      if (c == COUNT_LIMIT) begin
         r = c;
      end else begin
         r = c + count_type'(1);
      end
      return r;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign eff_wp        = req_tuser ? '0 : wp_ff;
   assign eff_count     = req_tuser ? '0 : count_ff;
   assign eff_mask_word = req_tuser ? '0 : mask_word_ff;
   assign eff_mask_bit  = req_tuser ? '0 : mask_bit_ff;
   assign eff_finished  = req_tuser ? 1'b0 : finished_ff;

   assign tok_is_ref = |(eff_mask_word & eff_mask_bit);
   assign tok_dist   = req_tdata[WORD_W-1:LENF_W];
   assign tok_len    = {1'b0, req_tdata[LENF_W-1:0]} + LEN_BIAS;
   assign dist_ptr   = ptr_type'(dist_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      count_in     = count_ff;
      mask_word_in = mask_word_ff;
      mask_bit_in  = mask_bit_ff;
      finished_in  = finished_ff;
      dist_in      = dist_ff;
      remain_in    = remain_ff;
      rsp_load     = 1'b0;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = wp_ff;
      wr_data      = req_tdata;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               wp_in        = eff_wp;
               count_in     = eff_count;
               mask_word_in = eff_mask_word;
               mask_bit_in  = eff_mask_bit;
               finished_in  = eff_finished;
               if (!eff_finished) begin
                  if (eff_mask_bit == '0) begin
                     mask_word_in = req_tdata;
                     mask_bit_in  = MASK_TOP;
                  end else begin
                     mask_bit_in = eff_mask_bit >> 1;
                     if (!tok_is_ref) begin
                        wr_en       = 1'b1;
                        wr_addr     = eff_wp;
                        wp_in       = ptr_next(eff_wp);
                        count_in    = count_sat(eff_count);
                        rsp_load    = 1'b1;
                        rsp_word_in = req_tdata;
                        rsp_last_in = 1'b1;
                        rsp_user_in = USER_NONE;
                     end else if (req_tdata == '0) begin
                        finished_in = 1'b1;
                        rsp_load    = 1'b1;
                        rsp_word_in = '0;
                        rsp_last_in = 1'b1;
                        rsp_user_in = USER_END;
                     end else if ((tok_dist == '0) || ({1'b0, tok_dist} > eff_count)) begin
                        rsp_load    = 1'b1;
                        rsp_word_in = '0;
                        rsp_last_in = 1'b1;
                        rsp_user_in = USER_BAD;
                     end else begin
                        dist_in   = tok_dist;
                        remain_in = tok_len;
                        state_in  = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            // Source slot lies dist words behind the write pointer, modulo depth.
            rd_en = 1'b1;
            if (wp_ff >= dist_ptr) begin
               rd_addr = wp_ff - dist_ptr;
            end else begin
               rd_addr = ptr_type'({1'b0, wp_ff} + (PTR_W + 1)'(HISTORY_DEPTH)
                                   - {1'b0, dist_ptr});
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               wr_en       = 1'b1;
               wr_addr     = wp_ff;
               wr_data     = rd_data;
               wp_in       = ptr_next(wp_ff);
               count_in    = count_sat(count_ff);
               rsp_load    = 1'b1;
               rsp_word_in = rd_data;
               rsp_last_in = (remain_ff == LEN_W'(1));
               rsp_user_in = USER_NONE;
               remain_in   = remain_ff - LEN_W'(1);
               state_in    = (remain_ff == LEN_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         count_ff     <= '0;
         mask_word_ff <= '0;
         mask_bit_ff  <= '0;
         finished_ff  <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         mask_word_ff <= mask_word_in;
         mask_bit_ff  <= mask_bit_in;
         finished_ff  <= finished_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   lzmwd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A copy in progress always has at least one word left to move.
   a_copy_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (remain_ff != '0))
      else $error("copy sequencer active with no words remaining");

   // The produced-word count never passes its saturation point.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("produced-word count beyond its limit");

   // After the end of a stream, words without a restart give no response.
   a_finished_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && finished_ff && !req_tuser) |-> !rsp_load)
      else $error("response produced after end of stream");

   // A response stalled on the output side keeps the copy from advancing.
   a_copy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && rsp_tvalid && !rsp_tready) |=>
         (state_ff == ST_WRITE && $stable(wp_ff)))
      else $error("copy advanced while the response was stalled");

endmodule
